/* hdl/fbpfl_pkg.sv */
// ----------------------------------------------------------------------------
// fbpfl_pkg
// Shared types and constants for the fixed block pool free list.
// ----------------------------------------------------------------------------
package fbpfl_pkg;

    localparam int DEF_MAX_BLOCKS = 1024;
    localparam int DEF_MAX_BATCH  = 16;

    localparam int OFF_W   = 22;
    localparam int BATCH_W = 5;
    localparam int SHIFT_W = 4;
    localparam int COUNT_W = 11;
    localparam int BYTES_W = 23;
    localparam int CFG_IDX_W = 1;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN  = 4'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 4'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_RST  = 4'd3;
    localparam logic [COUNT_W-1:0] BLOCKS_RST = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'h7FF;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_BATCH  = 2'd1,
        OP_FREE   = 2'd2,
        OP_RELINK = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_MISALIGN = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_ctl;

endpackage

/* hdl/fbpfl_ram.sv */
// ----------------------------------------------------------------------------
// fbpfl_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module fbpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/fbpfl_front.sv */
// ----------------------------------------------------------------------------
// fbpfl_front
// Accepts commands, checks free offsets, clamps batch counts and queues
// the classified commands for the execution side.
// ----------------------------------------------------------------------------
module fbpfl_front #(
    parameter int MAX_BLOCKS = fbpfl_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_BATCH  = fbpfl_pkg::DEF_MAX_BATCH,
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
    localparam int BW    = $clog2(MAX_BATCH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [31:0]                      i_s_tdata,
    input  logic [2:0]                       i_s_tuser,
    input  logic [fbpfl_pkg::SHIFT_W-1:0]    i_eff_shift,
    input  logic [CNT_W-1:0]                 i_eff_count,
    output logic                             o_q_valid,
    output fbpfl_pkg::t_ctl                  o_q_ctl,
    output logic [IDX_W-1:0]                 o_q_idx,
    output logic [BW-1:0]                    o_q_count,
    input  logic                             i_q_pop
);

    localparam int OW = fbpfl_pkg::OFF_W;

    fbpfl_pkg::t_ctl   r_q_ctl [2];
    logic [IDX_W-1:0]  r_q_idx [2];
    logic [BW-1:0]     r_q_cnt [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;

    fbpfl_pkg::t_op    cmd;
    logic              off_valid;
    logic [OW-1:0]     off;
    logic [fbpfl_pkg::BATCH_W-1:0] batch;
    logic [OW-1:0]     blk;
    logic [OW-1:0]     mask;
    fbpfl_pkg::t_ctl   ctl;
    logic [BW-1:0]     count;
    logic              push;

    assign cmd       = fbpfl_pkg::t_op'(i_s_tuser[1:0]);
    assign off_valid = i_s_tuser[2];
    assign off       = i_s_tdata[OW-1:0];
    assign batch     = i_s_tdata[OW +: fbpfl_pkg::BATCH_W];
    assign blk       = off >> i_eff_shift;
    assign mask      = (OW'(1) << i_eff_shift) - OW'(1);

    always_comb begin
        ctl.op     = cmd;
        ctl.status = fbpfl_pkg::ST_OK;
        count      = '0;
        unique case (cmd)
            fbpfl_pkg::OP_ALLOC: begin
                count = BW'(1);
            end
            fbpfl_pkg::OP_BATCH: begin
                if (32'(batch) > MAX_BATCH) begin
                    count = BW'(MAX_BATCH);
                end else begin
                    count = BW'(batch);
                end
            end
            fbpfl_pkg::OP_FREE: begin
                if (!off_valid) begin
                    ctl.status = fbpfl_pkg::ST_NULL;
                end else if (blk >= OW'(i_eff_count)) begin
                    ctl.status = fbpfl_pkg::ST_RANGE;
                end else if ((off & mask) != '0) begin
                    ctl.status = fbpfl_pkg::ST_MISALIGN;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_ctl[r_wp] <= ctl;
            r_q_idx[r_wp] <= IDX_W'(blk);
            r_q_cnt[r_wp] <= count;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_ctl   = r_q_ctl[r_rp];
    assign o_q_idx   = r_q_idx[r_rp];
    assign o_q_count = r_q_cnt[r_rp];

endmodule

/* hdl/fbpfl_back.sv */
// ----------------------------------------------------------------------------
// fbpfl_back
// Executes queued commands on the free list: pops from the list head or the
// fresh-block counter, pushes freed blocks, relinks the list on request, and holds the result register.
// ----------------------------------------------------------------------------
module fbpfl_back #(
    parameter int MAX_BLOCKS = fbpfl_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_BATCH  = fbpfl_pkg::DEF_MAX_BATCH,
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
    localparam int BW    = $clog2(MAX_BATCH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_relink,
    input  logic [fbpfl_pkg::SHIFT_W-1:0]    i_eff_shift,
    input  logic [CNT_W-1:0]                 i_eff_count,
    input  logic                             i_q_valid,
    input  fbpfl_pkg::t_ctl                  i_q_ctl,
    input  logic [IDX_W-1:0]                 i_q_idx,
    input  logic [BW-1:0]                    i_q_count,
    output logic                             o_q_pop,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [fbpfl_pkg::OFF_W-1:0]      o_off,
    output logic                             o_granted,
    output fbpfl_pkg::t_status               o_status,
    output logic [fbpfl_pkg::COUNT_W-1:0]    o_free_blocks,
    output logic [fbpfl_pkg::BYTES_W-1:0]    o_free_bytes,
    output logic                             o_last
);

    localparam int OW  = fbpfl_pkg::OFF_W;
    localparam int FW  = fbpfl_pkg::COUNT_W;
    localparam int BYW = fbpfl_pkg::BYTES_W;

    fbpfl_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic              r_head_ok, n_head_ok;
    logic [CNT_W-1:0]  r_fresh, n_fresh;
    logic [FW-1:0]     r_free, n_free;
    logic [BW-1:0]     r_left, n_left;

    logic                   r_ovalid;
    logic [OW-1:0]          r_o_off;
    logic                   r_o_gr;
    fbpfl_pkg::t_status     r_o_st;
    logic [FW-1:0]          r_o_free;
    logic [BYW-1:0]         r_o_bytes;
    logic                   r_o_last;

    logic                   emit;
    logic [OW-1:0]          e_off;
    logic                   e_gr;
    fbpfl_pkg::t_status     e_st;
    logic [FW-1:0]          e_free;
    logic                   e_last;

    logic                   ram_we, ram_re;
    logic [IDX_W:0]         ram_rdata;
    logic                   rd_ok;
    logic [IDX_W-1:0]       rd_idx;

    logic                   out_free;
    logic                   empty;
    logic [CNT_W:0]         fresh_inc;
    logic                   fresh_fin;
    logic                   link_fin;
    logic                   no_left;
    logic [FW-1:0]          free_dec, free_inc;

    fbpfl_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (MAX_BLOCKS)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_idx),
        .i_wdata ({r_head_ok, r_head}),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign rd_ok  = ram_rdata[IDX_W];
    assign rd_idx = ram_rdata[IDX_W-1:0];

    assign out_free  = !r_ovalid || i_m_tready;
    assign empty     = !r_head_ok && (r_fresh >= i_eff_count);
    assign fresh_inc = {1'b0, r_fresh} + (CNT_W + 1)'(1);
    assign no_left   = (r_left == '0);
    assign fresh_fin = (r_left == BW'(1)) || (fresh_inc >= {1'b0, i_eff_count});
    assign link_fin  = (r_left == BW'(1)) || (!rd_ok && (r_fresh >= i_eff_count));
    assign free_dec  = (r_free != '0) ? r_free - FW'(1) : r_free;
    assign free_inc  = (r_free != fbpfl_pkg::COUNT_MAX) ? r_free + FW'(1) : r_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbpfl_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = fbpfl_pkg::S_EXEC;
                end
            end
            fbpfl_pkg::S_EXEC: begin
                case (i_q_ctl.op) inside
                    fbpfl_pkg::OP_ALLOC, fbpfl_pkg::OP_BATCH: begin
                        if (no_left || empty) begin
                            if (out_free) begin
                                n_state = fbpfl_pkg::S_IDLE;
                            end
                        end else if (r_head_ok) begin
                            n_state = fbpfl_pkg::S_LINK;
                        end else if (out_free && fresh_fin) begin
                            n_state = fbpfl_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_state = fbpfl_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            fbpfl_pkg::S_LINK: begin
                if (out_free) begin
                    n_state = link_fin ? fbpfl_pkg::S_IDLE : fbpfl_pkg::S_EXEC;
                end
            end
            default: begin
                n_state = fbpfl_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head    = r_head;
        n_head_ok = r_head_ok;
        n_fresh   = r_fresh;
        n_free    = r_free;
        n_left    = r_left;
        emit      = 1'b0;
        e_off     = '0;
        e_gr      = 1'b0;
        e_st      = fbpfl_pkg::ST_OK;
        e_free    = r_free;
        e_last    = 1'b1;
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        unique case (r_state)
            fbpfl_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_left = i_q_count;
                end
            end
            fbpfl_pkg::S_EXEC: begin
                case (i_q_ctl.op) inside
                    fbpfl_pkg::OP_ALLOC, fbpfl_pkg::OP_BATCH: begin
                        if (no_left || empty) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                e_st    = no_left ? fbpfl_pkg::ST_OK : fbpfl_pkg::ST_EMPTY;
                                o_q_pop = 1'b1;
                            end
                        end else if (r_head_ok) begin
                            ram_re = 1'b1;
                        end else if (out_free) begin
                            emit    = 1'b1;
                            e_off   = OW'(r_fresh) << i_eff_shift;
                            e_gr    = 1'b1;
                            e_free  = free_dec;
                            e_last  = fresh_fin;
                            n_fresh = fresh_inc[CNT_W-1:0];
                            n_free  = free_dec;
                            n_left  = r_left - BW'(1);
                            o_q_pop = fresh_fin;
                        end
                    end
                    fbpfl_pkg::OP_FREE: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            e_st    = i_q_ctl.status;
                            o_q_pop = 1'b1;
                            if (i_q_ctl.status == fbpfl_pkg::ST_OK) begin
                                ram_we    = 1'b1;
                                n_head    = i_q_idx;
                                n_head_ok = 1'b1;
                                n_free    = free_inc;
                                e_free    = free_inc;
                            end
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit      = 1'b1;
                            o_q_pop   = 1'b1;
                            n_head_ok = 1'b0;
                            n_fresh   = '0;
                            n_free    = FW'(i_eff_count);
                            e_free    = FW'(i_eff_count);
                        end
                    end
                endcase
            end
            fbpfl_pkg::S_LINK: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_off     = OW'(r_head) << i_eff_shift;
                    e_gr      = 1'b1;
                    e_free    = free_dec;
                    e_last    = link_fin;
                    n_head    = rd_idx;
                    n_head_ok = rd_ok;
                    n_free    = free_dec;
                    n_left    = r_left - BW'(1);
                    o_q_pop   = link_fin;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fbpfl_pkg::S_IDLE;
            r_head_ok <= 1'b0;
            r_fresh   <= '0;
            r_free    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_relink) begin
                r_head_ok <= 1'b0;
                r_fresh   <= '0;
                r_free    <= FW'(i_eff_count);
            end else begin
                r_head_ok <= n_head_ok;
                r_fresh   <= n_fresh;
                r_free    <= n_free;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_left <= n_left;
        if (emit) begin
            r_o_off   <= e_off;
            r_o_gr    <= e_gr;
            r_o_st    <= e_st;
            r_o_free  <= e_free;
            r_o_bytes <= BYW'(e_free) << i_eff_shift;
            r_o_last  <= e_last;
        end
    end

    assign o_m_tvalid    = r_ovalid;
    assign o_off         = r_o_off;
    assign o_granted     = r_o_gr;
    assign o_status      = r_o_st;
    assign o_free_blocks = r_o_free;
    assign o_free_bytes  = r_o_bytes;
    assign o_last        = r_o_last;

endmodule

/* hdl/fixed_block_pool_free_list.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_free_list
// LIFO free list over a pool of equal power-of-two sized blocks.
// Results: a request passes the input queue, the idle state and the execute
// state into the result register; a block off the list head also passes the
// link state for the link RAM read. The input queue holds two requests, run
// one at a time. Batch grants one block per cycle from fresh blocks while the
// result side is ready; list head blocks alternate execute and link states.
// Reset: synchronous, active low; list relinked in ascending order, no
// clearing pass. A configuration write also relinks the list.
// ----------------------------------------------------------------------------
module fixed_block_pool_free_list #(
    parameter int MAX_BLOCKS = fbpfl_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_BATCH  = fbpfl_pkg::DEF_MAX_BATCH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config
    input  logic                              i_cfg_we,
    input  logic [fbpfl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fbpfl_pkg::COUNT_W-1:0]     i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [31:0]                       i_s_tdata,  // block_offset, batch_count
    input  logic [2:0]                        i_s_tuser,  // command, offset_valid
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [55:0]                       o_m_tdata,  // granted_offset, free_blocks, free_bytes
    output logic [3:0]                        o_m_tuser,  // granted, status
    output logic                              o_m_tlast
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int BW    = $clog2(MAX_BATCH + 1);

    logic [fbpfl_pkg::SHIFT_W-1:0] r_shift;
    logic [fbpfl_pkg::COUNT_W-1:0] r_blocks;
    logic                          r_relink;
    logic [fbpfl_pkg::SHIFT_W-1:0] eff_shift;
    logic [CNT_W-1:0]              eff_count;

    logic                          q_valid;
    fbpfl_pkg::t_ctl               q_ctl;
    logic [IDX_W-1:0]              q_idx;
    logic [BW-1:0]                 q_count;
    logic                          q_pop;

    logic [fbpfl_pkg::OFF_W-1:0]   res_off;
    logic                          res_gr;
    fbpfl_pkg::t_status            res_st;
    logic [fbpfl_pkg::COUNT_W-1:0] res_free;
    logic [fbpfl_pkg::BYTES_W-1:0] res_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= fbpfl_pkg::SHIFT_RST;
            r_blocks <= fbpfl_pkg::BLOCKS_RST;
            r_relink <= 1'b1;
        end else begin
            r_relink <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fbpfl_pkg::CFG_SHIFT:  r_shift  <= i_cfg_data[fbpfl_pkg::SHIFT_W-1:0];
                    fbpfl_pkg::CFG_BLOCKS: r_blocks <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (r_shift < fbpfl_pkg::SHIFT_MIN) begin
            eff_shift = fbpfl_pkg::SHIFT_MIN;
        end else if (r_shift > fbpfl_pkg::SHIFT_MAX) begin
            eff_shift = fbpfl_pkg::SHIFT_MAX;
        end else begin
            eff_shift = r_shift;
        end
        if (r_blocks == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(r_blocks) > MAX_BLOCKS) begin
            eff_count = CNT_W'(MAX_BLOCKS);
        end else begin
            eff_count = CNT_W'(r_blocks);
        end
    end

    fbpfl_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_BATCH  (MAX_BATCH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_eff_shift (eff_shift),
        .i_eff_count (eff_count),
        .o_q_valid   (q_valid),
        .o_q_ctl     (q_ctl),
        .o_q_idx     (q_idx),
        .o_q_count   (q_count),
        .i_q_pop     (q_pop)
    );

    fbpfl_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_BATCH  (MAX_BATCH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_relink      (r_relink),
        .i_eff_shift   (eff_shift),
        .i_eff_count   (eff_count),
        .i_q_valid     (q_valid),
        .i_q_ctl       (q_ctl),
        .i_q_idx       (q_idx),
        .i_q_count     (q_count),
        .o_q_pop       (q_pop),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_off         (res_off),
        .o_granted     (res_gr),
        .o_status      (res_st),
        .o_free_blocks (res_free),
        .o_free_bytes  (res_bytes),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {res_bytes, res_free, res_off};
    assign o_m_tuser = {res_st, res_gr};

endmodule

/* bench/tb_fixed_block_pool_free_list.sv */
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_free_list
// Self-checking bench for the block pool free list. A scoreboard keeps its own
// copy of the list (links, head, fresh-block counter, free count) and predicts
// every result of each accepted request. Directed requests cover empty pools,
// early batch stop, null/range/alignment rejects and double frees. A run of
// frees on a full pool lifts the free count above the pool size. Random phases
// then run under varied register settings, most with bursty input and a stalling
// result side.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_free_list;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpfl_pkg::*;

    localparam longint unsigned BYTES_SAT = (64'd1 << BYTES_W) - 1;

    typedef struct {
        logic [OFF_W-1:0]   offset;
        logic               granted;
        logic [2:0]         status;
        logic [COUNT_W-1:0] free_blocks;
        logic [BYTES_W-1:0] free_bytes;
        logic               last;
    } t_grant_rec;

    class free_list_scoreboard;
        bit [SHIFT_W-1:0]   shift_reg;
        bit [COUNT_W-1:0]   blocks_reg;
        bit [COUNT_W-1:0]   link_mem [DEF_MAX_BLOCKS];
        bit                 link_ok  [DEF_MAX_BLOCKS];
        bit [COUNT_W-1:0]   head;
        bit                 head_ok;
        int                 fresh;
        int                 free_total;
        t_grant_rec         expected[$];
        bit [OFF_W-1:0]     held[$];
        int                 faults;
        int                 n_requests;
        int                 n_results;
        int                 n_grants;
        int                 n_empty;
        int                 n_rejects;
        int                 n_writes;

        function new();
            shift_reg  = SHIFT_RST;
            blocks_reg = BLOCKS_RST;
            relink();
        endfunction

        function int eff_shift();
            if (shift_reg < SHIFT_MIN) return int'(SHIFT_MIN);
            if (shift_reg > SHIFT_MAX) return int'(SHIFT_MAX);
            return int'(shift_reg);
        endfunction

        function int eff_count();
            if (blocks_reg == 0) return 1;
            if (blocks_reg > DEF_MAX_BLOCKS) return DEF_MAX_BLOCKS;
            return int'(blocks_reg);
        endfunction

        function void relink();
            head_ok    = 1'b0;
            head       = '0;
            fresh      = 0;
            free_total = eff_count();
            held.delete();
        endfunction

        function bit pool_dry();
            return !head_ok && fresh >= eff_count();
        endfunction

        function int take_block();
            int b;
            if (head_ok) begin
                b       = int'(head);
                head_ok = link_ok[b];
                head    = link_mem[b];
            end else begin
                b     = fresh;
                fresh = fresh + 1;
            end
            if (free_total > 0) free_total--;
            return b;
        endfunction

        function void post(longint unsigned off, bit gr, t_status st, bit fin);
            t_grant_rec      r;
            longint unsigned bytes;
            bytes = longint'(free_total) << eff_shift();
            if (bytes > BYTES_SAT) bytes = BYTES_SAT;
            r.offset      = off[OFF_W-1:0];
            r.granted     = gr;
            r.status      = st;
            r.free_blocks = free_total[COUNT_W-1:0];
            r.free_bytes  = bytes[BYTES_W-1:0];
            r.last        = fin;
            expected.push_back(r);
            if (gr) begin
                n_grants++;
                held.push_back(r.offset);
            end
            if (st == ST_EMPTY) n_empty++;
            if (st == ST_NULL || st == ST_RANGE || st == ST_MISALIGN) n_rejects++;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [COUNT_W-1:0] data);
            if (idx == CFG_SHIFT) shift_reg = data[SHIFT_W-1:0];
            else blocks_reg = data;
            n_writes++;
            relink();
        endfunction

        function void note_request(t_op op, bit [OFF_W-1:0] off, bit valid,
                                   bit [BATCH_W-1:0] cnt);
            int              sh;
            int              want;
            int              b;
            longint unsigned limit;
            longint unsigned mask;
            sh = eff_shift();
            n_requests++;
            case (op)
                OP_ALLOC: begin
                    if (pool_dry()) begin
                        post(0, 1'b0, ST_EMPTY, 1'b1);
                    end else begin
                        b = take_block();
                        post(longint'(b) << sh, 1'b1, ST_OK, 1'b1);
                    end
                end
                OP_BATCH: begin
                    want = (cnt > DEF_MAX_BATCH) ? DEF_MAX_BATCH : int'(cnt);
                    if (want == 0) begin
                        post(0, 1'b0, ST_OK, 1'b1);
                    end else if (pool_dry()) begin
                        post(0, 1'b0, ST_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < want && !pool_dry(); i++) begin
                            b = take_block();
                            post(longint'(b) << sh, 1'b1, ST_OK, (i + 1 == want) || pool_dry());
                        end
                    end
                end
                OP_FREE: begin
                    limit = longint'(eff_count()) << sh;
                    mask  = (64'd1 << sh) - 1;
                    if (!valid) begin
                        post(0, 1'b0, ST_NULL, 1'b1);
                    end else if (off >= limit) begin
                        post(0, 1'b0, ST_RANGE, 1'b1);
                    end else if ((off & mask) != 0) begin
                        post(0, 1'b0, ST_MISALIGN, 1'b1);
                    end else begin
                        b           = int'(off >> sh);
                        link_mem[b] = head;
                        link_ok[b]  = head_ok;
                        head        = b[COUNT_W-1:0];
                        head_ok     = 1'b1;
                        if (free_total < int'(COUNT_MAX)) free_total++;
                        post(0, 1'b0, ST_OK, 1'b1);
                    end
                end
                default: begin
                    relink();
                    post(0, 1'b0, ST_OK, 1'b1);
                end
            endcase
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10) $display("%0t ns  %s", $time, msg);
        endfunction

        function void check_result(t_grant_rec got);
            t_grant_rec e;
            n_results++;
            if (expected.size() == 0) begin
                flag($sformatf("unexpected result off=%h gr=%b st=%0d blk=%0d bytes=%0d last=%b",
                               got.offset, got.granted, got.status, got.free_blocks,
                               got.free_bytes, got.last));
                return;
            end
            e = expected.pop_front();
            if (got.offset !== e.offset || got.granted !== e.granted ||
                got.status !== e.status || got.free_blocks !== e.free_blocks ||
                got.free_bytes !== e.free_bytes || got.last !== e.last) begin
                flag($sformatf({"mismatch exp off=%h gr=%b st=%0d blk=%0d bytes=%0d last=%b",
                                " / got off=%h gr=%b st=%0d blk=%0d bytes=%0d last=%b"},
                               e.offset, e.granted, e.status, e.free_blocks, e.free_bytes,
                               e.last, got.offset, got.granted, got.status, got.free_blocks,
                               got.free_bytes, got.last));
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [COUNT_W-1:0]    cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [55:0]           m_tdata;
    logic [3:0]            m_tuser;
    logic                  m_tlast;

    bit                    rx_stalls = 1'b0;
    int                    rx_run = 0;

    free_list_scoreboard   sb = new();

    always #1 clk = ~clk;

    fixed_block_pool_free_list DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // result side: alternating ready and stall runs
    always @(negedge clk) begin
        if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else if (rx_run == 0) begin
            m_tready <= ~m_tready;
            rx_run   <= m_tready ? $urandom_range(1, 4) : $urandom_range(1, 8);
        end else begin
            rx_run <= rx_run - 1;
        end
    end

    always @(posedge clk) begin
        t_grant_rec got;
        if (rst_n && m_tvalid && m_tready) begin
            got.offset      = m_tdata[21:0];
            got.free_blocks = m_tdata[32:22];
            got.free_bytes  = m_tdata[55:33];
            got.granted     = m_tuser[0];
            got.status      = m_tuser[3:1];
            got.last        = m_tlast;
            sb.check_result(got);
        end
    end

    task automatic send_item(t_op op, bit [OFF_W-1:0] off, bit valid, bit [BATCH_W-1:0] cnt);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, cnt, off};
        s_tuser  = {valid, op};
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, off, valid, cnt);
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.expected.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [COUNT_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_pool(bit [SHIFT_W-1:0] shift, bit [COUNT_W-1:0] blocks);
        drain();
        write_reg(CFG_SHIFT, {7'($urandom_range(0, 127)), shift});
        write_reg(CFG_BLOCKS, blocks);
    endtask

    task automatic random_item();
        int              r;
        int              sh;
        int              cnt;
        int              k;
        bit [OFF_W-1:0]  off;
        bit              valid;
        bit [BATCH_W-1:0] want;
        longint unsigned limit;
        r     = $urandom_range(0, 99);
        sh    = sb.eff_shift();
        cnt   = sb.eff_count();
        limit = longint'(cnt) << sh;
        off   = OFF_W'($urandom);
        valid = 1'($urandom);
        want  = ($urandom_range(0, 99) < 85) ? BATCH_W'($urandom_range(1, 16))
                                             : BATCH_W'($urandom_range(0, 31));
        if (r < 30) begin
            send_item(OP_ALLOC, off, valid, want);
        end else if (r < 50) begin
            send_item(OP_BATCH, off, valid, want);
        end else if (r < 96) begin
            if (sb.held.size() != 0 && $urandom_range(0, 7) != 0) begin
                k   = $urandom_range(0, sb.held.size() - 1);
                off = sb.held[k];
                sb.held.delete(k);
                valid = 1'b1;
            end else begin
                case ($urandom_range(0, 4))
                    0: valid = 1'b0;
                    1: valid = 1'b1;
                    2: begin
                        valid = 1'b1;
                        off   = OFF_W'(longint'($urandom_range(0, cnt - 1)) << sh);
                    end
                    3: begin
                        valid = 1'b1;
                        off   = OFF_W'((longint'($urandom_range(0, cnt - 1)) << sh) |
                                       $urandom_range(1, (1 << sh) - 1));
                    end
                    default: begin
                        valid = 1'b1;
                        if (limit <= 64'h3FFFFF)
                            off = OFF_W'(limit + $urandom_range(0, 64'h3FFFFF - limit));
                    end
                endcase
            end
            send_item(OP_FREE, off, valid, want);
        end else begin
            send_item(OP_RELINK, off, valid, want);
        end
    endtask

    initial begin
        int burst;
        int spin;
        bit [COUNT_W-1:0] blocks;
        int r;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // two blocks of eight bytes: empty pool, rejects, double free
        set_pool(4'd0, 11'd2);
        send_item(OP_ALLOC, 22'h3FFFFF, 1'b1, 5'd31);
        send_item(OP_ALLOC, '0, 1'b0, 5'd0);
        send_item(OP_ALLOC, '0, 1'b0, 5'd1);
        send_item(OP_BATCH, '0, 1'b0, 5'd3);
        send_item(OP_FREE, 22'h3FFFFF, 1'b0, 5'd31);
        send_item(OP_FREE, 22'd16, 1'b1, 5'd0);
        send_item(OP_FREE, 22'd4, 1'b1, 5'd0);
        send_item(OP_FREE, 22'd8, 1'b1, 5'd0);
        send_item(OP_FREE, 22'd0, 1'b1, 5'd0);
        send_item(OP_FREE, 22'd0, 1'b1, 5'd0);
        send_item(OP_BATCH, '0, 1'b1, 5'd0);
        send_item(OP_BATCH, '0, 1'b1, 5'd31);
        send_item(OP_RELINK, 22'h3FFFFF, 1'b1, 5'd31);
        send_item(OP_BATCH, '0, 1'b1, 5'd3);

        // largest blocks, single-block pool
        set_pool(4'd15, 11'd0);
        send_item(OP_ALLOC, '0, 1'b1, 5'd1);
        send_item(OP_ALLOC, '0, 1'b1, 5'd1);
        send_item(OP_FREE, 22'd4096, 1'b1, 5'd1);
        send_item(OP_FREE, 22'h3FFFFF, 1'b1, 5'd1);
        send_item(OP_FREE, 22'd2048, 1'b1, 5'd1);
        send_item(OP_FREE, 22'd0, 1'b1, 5'd1);
        send_item(OP_RELINK, '0, 1'b0, 5'd0);

        // oversized block count clamps to the pool maximum
        set_pool(4'd12, 11'd2047);
        send_item(OP_BATCH, '0, 1'b0, 5'd16);
        send_item(OP_FREE, 22'h3FF000, 1'b1, 5'd16);
        send_item(OP_ALLOC, '0, 1'b0, 5'd16);

        // repeated frees on a full pool push the free count past the pool size
        set_pool(4'd12, 11'd1024);
        repeat (60) send_item(OP_FREE, OFF_W'($urandom_range(0, 1023) << 12), 1'b1,
                              BATCH_W'($urandom));
        rx_stalls = 1'b1;
        repeat (12) send_item(OP_BATCH, OFF_W'($urandom), 1'($urandom), 5'd16);
        rx_stalls = 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            r = $urandom_range(0, 99);
            if (r < 60)      blocks = COUNT_W'($urandom_range(1, 24));
            else if (r < 70) blocks = COUNT_W'($urandom_range(0, 2));
            else if (r < 82) blocks = 11'd1024;
            else if (r < 90) blocks = 11'd2047;
            else             blocks = COUNT_W'($urandom);
            set_pool(SHIFT_W'($urandom), blocks);
            rx_stalls = (ph % 3 != 0);
            burst = $urandom_range(1, 12);
            repeat (33) begin
                random_item();
                burst--;
                if (burst == 0) begin
                    if (ph % 3 != 0) pause_sender($urandom_range(1, 6));
                    burst = $urandom_range(1, 12);
                end
            end
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        spin = 0;
        while (sb.expected.size() != 0 && spin < 5000) begin
            @(negedge clk);
            spin++;
        end
        repeat (10) @(posedge clk);
        if (sb.expected.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.expected.size()));

        $display("run covered %0d requests, %0d results, %0d register writes",
                 sb.n_requests, sb.n_results, sb.n_writes);
        $display("blocks granted %0d, empty-pool replies %0d, rejected frees %0d, failures %0d",
                 sb.n_grants, sb.n_empty, sb.n_rejects, sb.faults);
        if (sb.faults == 0) begin
            $display("tb_fixed_block_pool_free_list: clean");
        end else begin
            $display("tb_fixed_block_pool_free_list: errors");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout waiting for transfers");
        $display("tb_fixed_block_pool_free_list: errors");
        $finish;
    end

endmodule
